// ===== rtl/fixed_point_alu_macros.svh =====
`ifndef FIXED_POINT_ALU_MACROS_SVH
`define FIXED_POINT_ALU_MACROS_SVH

// same-cycle implication
`define FPA_ASSERT_IMPLY(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication
`define FPA_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== rtl/fpa_pkg.sv =====
package fpa_pkg;

   localparam int WORD_W            = 32;
   localparam int FRAC_BITS_DEFAULT = 8;
   localparam int QUEUE_DEPTH       = 4;
   localparam int QUEUE_PTR_W       = $clog2(QUEUE_DEPTH);

   typedef enum logic [3:0] {
      OP_ADD = 4'd0,
      OP_SUB = 4'd1,
      OP_MUL = 4'd2,
      OP_DIV = 4'd3,
      OP_GT  = 4'd4,
      OP_LT  = 4'd5,
      OP_GE  = 4'd6,
      OP_LE  = 4'd7,
      OP_EQ  = 4'd8,
      OP_NE  = 4'd9,
      OP_MIN = 4'd10,
      OP_MAX = 4'd11,
      OP_INC = 4'd12,
      OP_DEC = 4'd13
   } fpa_op_type;

   typedef enum logic [1:0] {
      KIND_ALU = 2'd0,
      KIND_MUL = 2'd1,
      KIND_DIV = 2'd2
   } fpa_kind_type;

   typedef struct packed {
      fpa_kind_type      kind;
      logic              neg;
      logic [WORD_W-1:0] mag_a;
      logic [WORD_W-1:0] mag_b;
      logic [WORD_W-1:0] res;
      logic              cmp;
      logic              dz;
   } fpa_item_type;

endpackage

// ===== rtl/fpa_front.sv =====
module fpa_front
   import fpa_pkg::*;
(
   input  logic [3:0]               req_type,
   input  logic signed [WORD_W-1:0] req_operand_a,
   input  logic signed [WORD_W-1:0] req_operand_b,
   output fpa_item_type             item
);

   logic a_gt_b;
   logic b_gt_a;

   assign a_gt_b = req_operand_a > req_operand_b;
   assign b_gt_a = req_operand_b > req_operand_a;

   always_comb begin
      item       = '0;
      item.kind  = KIND_ALU;
      item.neg   = req_operand_a[WORD_W-1] ^ req_operand_b[WORD_W-1];
      item.mag_a = req_operand_a[WORD_W-1] ? -req_operand_a : req_operand_a;
      item.mag_b = req_operand_b[WORD_W-1] ? -req_operand_b : req_operand_b;
      case (req_type)
         OP_ADD: item.res = req_operand_a + req_operand_b;
         OP_SUB: item.res = req_operand_a - req_operand_b;
         OP_MUL: item.kind = KIND_MUL;
         OP_DIV: begin
            if (req_operand_b == '0) begin
               item.dz = 1'b1;
            end else begin
               item.kind = KIND_DIV;
            end
         end
         OP_GT:  item.cmp = a_gt_b;
         OP_LT:  item.cmp = b_gt_a;
         OP_GE:  item.cmp = !b_gt_a;
         OP_LE:  item.cmp = !a_gt_b;
         OP_EQ:  item.cmp = req_operand_a == req_operand_b;
         OP_NE:  item.cmp = req_operand_a != req_operand_b;
         OP_MIN: item.res = a_gt_b ? req_operand_b : req_operand_a;
         OP_MAX: item.res = a_gt_b ? req_operand_a : req_operand_b;
         OP_INC: item.res = req_operand_a + 32'sd1;
         OP_DEC: item.res = req_operand_a - 32'sd1;
         default: ;
      endcase
   end

endmodule

// ===== rtl/fpa_queue.sv =====
module fpa_queue
   import fpa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  fpa_item_type wr_item,
   output logic         full,
   input  logic         pop,
   output fpa_item_type rd_item,
   output logic         empty
);

   fpa_item_type           mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_W:0]   count_ff;
   logic [QUEUE_PTR_W:0]   count_in;
   logic                   wr_en;
   logic                   rd_en;

   assign full    = count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH);
   assign empty   = count_ff == '0;
   assign wr_en   = push && !full;
   assign rd_en   = pop && !empty;
   assign rd_item = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (wr_en) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (rd_en) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

endmodule

// ===== rtl/fpa_back.sv =====
`include "fixed_point_alu_macros.svh"

module fpa_back
   import fpa_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  fpa_item_type             q_item,
   input  logic                     q_empty,
   output logic                     q_pop,
   output logic signed [WORD_W-1:0] rsp_raw_result,
   output logic                     rsp_compare_true,
   output logic                     rsp_divide_by_zero,
   output logic                     rsp_empty,
   input  logic                     rsp_pop
);

   localparam int NUM_STEPS = WORD_W + FRAC_BITS;
   localparam int LAST      = NUM_STEPS + 1;

   typedef struct packed {
      logic                valid;
      fpa_kind_type        kind;
      logic                neg;
      logic [WORD_W-1:0]   res;
      logic                cmp;
      logic                dz;
      logic [2*WORD_W-1:0] prod;
      logic [WORD_W:0]     rem;
      logic [WORD_W-1:0]   num;
      logic [WORD_W-1:0]   den;
   } fpa_stage_type;

   fpa_stage_type stage_ff [LAST+1];
   fpa_stage_type stage_in [LAST+1];
   logic          adv;

   assign adv   = !stage_ff[LAST].valid || rsp_pop;
   assign q_pop = adv && !q_empty;

   always_comb begin
      stage_in[0]       = '0;
      stage_in[0].valid = !q_empty;
      stage_in[0].kind  = q_item.kind;
      stage_in[0].neg   = q_item.neg;
      stage_in[0].res   = q_item.res;
      stage_in[0].cmp   = q_item.cmp;
      stage_in[0].dz    = q_item.dz;
      stage_in[0].num   = q_item.mag_a;
      stage_in[0].den   = q_item.mag_b;
   end

   // one quotient bit per stage, multiply and rounding ride in the same pipe
   for (genvar k = 0; k < LAST; k++) begin : g_step
      always_comb begin : step_b
         logic [WORD_W:0]     rem_sh;
         logic                bit_in;
         logic [2*WORD_W-1:0] prod_full;
         logic [2*WORD_W-1:0] prod_sh;
         logic [WORD_W-1:0]   quo;
         stage_in[k+1] = stage_ff[k];
         rem_sh    = '0;
         bit_in    = 1'b0;
         prod_full = '0;
         prod_sh   = '0;
         quo       = '0;
         case (stage_ff[k].kind)
            KIND_MUL: begin
               if (k == 0) begin
                  prod_full = stage_ff[k].num * stage_ff[k].den;
                  stage_in[k+1].prod = prod_full;
               end
               if (k == 1) begin
                  prod_sh = stage_ff[k].prod >> FRAC_BITS;
                  stage_in[k+1].res = prod_sh[WORD_W-1:0]
                     + {{(WORD_W-1){1'b0}}, stage_ff[k].prod[FRAC_BITS-1]};
               end
               if (k == NUM_STEPS) begin
                  stage_in[k+1].res = stage_ff[k].neg ? -stage_ff[k].res : stage_ff[k].res;
               end
            end
            KIND_DIV: begin
               if (k < NUM_STEPS) begin
                  bit_in = (k < WORD_W) ? stage_ff[k].num[WORD_W-1] : 1'b0;
                  rem_sh = {stage_ff[k].rem[WORD_W-1:0], bit_in};
                  if (rem_sh >= {1'b0, stage_ff[k].den}) begin
                     rem_sh = rem_sh - {1'b0, stage_ff[k].den};
                     quo    = {stage_ff[k].res[WORD_W-2:0], 1'b1};
                  end else begin
                     quo    = {stage_ff[k].res[WORD_W-2:0], 1'b0};
                  end
                  stage_in[k+1].rem = rem_sh;
                  stage_in[k+1].res = quo;
                  stage_in[k+1].num = {stage_ff[k].num[WORD_W-2:0], 1'b0};
               end else begin
                  // round half away from zero on the magnitude
                  quo = stage_ff[k].res + {{(WORD_W-1){1'b0}},
                     ({stage_ff[k].rem, 1'b0} >= {2'b00, stage_ff[k].den})};
                  stage_in[k+1].res = stage_ff[k].neg ? -quo : quo;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= LAST; i++) begin
            stage_ff[i].valid <= 1'b0;
         end
      end else if (adv) begin
         for (int i = 0; i <= LAST; i++) begin
            stage_ff[i] <= stage_in[i];
         end
      end
   end

   assign rsp_empty          = !stage_ff[LAST].valid;
   assign rsp_raw_result     = stage_ff[LAST].res;
   assign rsp_compare_true   = stage_ff[LAST].cmp;
   assign rsp_divide_by_zero = stage_ff[LAST].dz;

   `FPA_ASSERT_IMPLY(a_dz_clean, clock, reset, !rsp_empty && rsp_divide_by_zero,
      rsp_raw_result == '0 && !rsp_compare_true, "divide by zero beat carries data")
   `FPA_ASSERT_IMPLY(a_cmp_clean, clock, reset, !rsp_empty && rsp_compare_true,
      rsp_raw_result == '0, "compare beat carries a raw result")
   `FPA_ASSERT_IMPLY(a_arith_flags, clock, reset,
      !rsp_empty && stage_ff[LAST].kind != KIND_ALU,
      !rsp_compare_true && !rsp_divide_by_zero, "mul or div beat carries flags")
   `FPA_ASSERT_NEXT(a_pipe_move, clock, reset, stage_ff[LAST-1].valid && adv,
      stage_ff[LAST].valid, "beat lost in pipeline")

endmodule

// ===== rtl/fixed_point_alu.sv =====
// Signed fixed-point ALU on raw 32-bit words with FRAC_BITS fraction bits: add, sub, mul, div,
// six compares, min, max, inc and dec, wrapping on overflow, mul and div rounded half away
// from zero, div by zero giving a zero result and the divide_by_zero flag. One beat is taken
// per cycle while req_full is low, and results leave in request order on the rsp_ side. Every
// request passes through the restoring divider pipeline, which retires one quotient bit per
// stage over 32 + FRAC_BITS stages, whatever its operation. A four-entry queue before the
// pipeline keeps taking beats while a result waits, until it is full.
module fixed_point_alu
   import fpa_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   output logic                     req_full,
   input  logic [3:0]               req_type,
   input  logic signed [WORD_W-1:0] req_operand_a,
   input  logic signed [WORD_W-1:0] req_operand_b,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output logic signed [WORD_W-1:0] rsp_raw_result,
   output logic                     rsp_compare_true,
   output logic                     rsp_divide_by_zero
);

   fpa_item_type front_item;
   fpa_item_type q_item;
   logic         q_empty;
   logic         q_pop;

   fpa_front u_front (
      .req_type      (req_type),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .item          (front_item)
   );

   fpa_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .wr_item (front_item),
      .full    (req_full),
      .pop     (q_pop),
      .rd_item (q_item),
      .empty   (q_empty)
   );

   fpa_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_item             (q_item),
      .q_empty            (q_empty),
      .q_pop              (q_pop),
      .rsp_raw_result     (rsp_raw_result),
      .rsp_compare_true   (rsp_compare_true),
      .rsp_divide_by_zero (rsp_divide_by_zero),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop)
   );

endmodule
